// ===== hdl/domain_name_validator_core_defines.svh =====
// ---------------------------------------------------------------------------
// Domain name validator assertion macros
// Shared concurrent assertion forms, clocked on clk with async reset arst_n.
// ---------------------------------------------------------------------------
`ifndef DOMAIN_NAME_VALIDATOR_CORE_DEFINES_SVH
`define DOMAIN_NAME_VALIDATOR_CORE_DEFINES_SVH

// condition must hold at every edge
`define DNV_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DNV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dnv_pkg.sv =====
// ---------------------------------------------------------------------------
// dnv_pkg
// Types, register indexes, reset values and character codes of the validator.
// ---------------------------------------------------------------------------
package dnv_pkg;

	localparam int CHAR_W     = 8;
	localparam int CNT_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef logic [CHAR_W-1:0]     char_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_MAX_TOTAL = 2'd0;
	localparam cfg_idx_t REG_MAX_LABEL = 2'd1;
	localparam cfg_idx_t REG_MIN_TLD   = 2'd2;

	localparam cnt_t RST_MAX_TOTAL = 8'd253;
	localparam cnt_t RST_MAX_LABEL = 8'd63;
	localparam cnt_t RST_MIN_TLD   = 8'd2;
	localparam cnt_t CNT_MAX       = 8'hFF;

	localparam char_t CH_NUL    = 8'h00;
	localparam char_t CH_DOT    = 8'h2E;
	localparam char_t CH_HYPHEN = 8'h2D;
	localparam char_t CH_LO_A   = 8'h61;
	localparam char_t CH_LO_Z   = 8'h7A;
	localparam char_t CH_UP_A   = 8'h41;
	localparam char_t CH_UP_Z   = 8'h5A;
	localparam char_t CH_DIG_0  = 8'h30;
	localparam char_t CH_DIG_9  = 8'h39;

	function automatic logic is_letter(input char_t c);
		return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
	endfunction

	function automatic logic is_digit(input char_t c);
		return c inside {[CH_DIG_0:CH_DIG_9]};
	endfunction

endpackage

// ===== hdl/dnv_channels.sv =====
// ---------------------------------------------------------------------------
// Validator channels
// Valid/ready channels for the character stream and the verdict.
// ---------------------------------------------------------------------------
interface dnv_char_if;
	logic           valid;
	logic           ready;
	dnv_pkg::char_t char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

interface dnv_verdict_if;
	logic valid;
	logic ready;
	logic name_valid;

	modport source (output valid, output name_valid, input ready);
	modport sink   (input valid, input name_valid, output ready);
endinterface

// ===== hdl/domain_name_validator_core.sv =====
// ---------------------------------------------------------------------------
// domain_name_validator_core
// Hostname syntax checker, one character item per cycle while no verdict stalls it.
// ---------------------------------------------------------------------------
// Usage:
//   char_stream carries the name one byte per item; a zero byte ends the
//   name. Only the terminating item yields a verdict item on verdict,
//   name_valid = 1 when the name passed all syntax rules.
//   Limits are set through cfg_we/cfg_index/cfg_data while the block is idle;
//   indexes past the last register are ignored.
// Timing:
//   One item per cycle sustained while no terminator waits on a pending verdict.
//   A byte is captured in the input register, checked against the per-name
//   counters in the next cycle, and a verdict lands in the output register:
//   valid rises once the terminator leaves the check stage.
// Reset:
//   arst_n clears the pipeline and per-name state and loads the default
//   limits 253, 63 and 2.
// Stall:
//   A pending verdict waits in the output register; characters keep flowing
//   until a second terminator reaches the check stage, which then holds and
//   ready drops.
// ---------------------------------------------------------------------------
module domain_name_validator_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  dnv_pkg::cfg_idx_t     cfg_index,
	input  dnv_pkg::cfg_data_t    cfg_data,
	dnv_char_if.sink              char_stream,
	dnv_verdict_if.source         verdict
);
	import dnv_pkg::*;

`include "domain_name_validator_core_defines.svh"

	cnt_t  max_total_q, max_label_q, min_tld_q;

	logic  valid_s1;
	char_t char_s1;

	logic  fail_q;
	cnt_t  total_count_q;
	cnt_t  label_count_q;
	logic  prev_hyphen_q;
	logic  all_letters_q;

	logic  out_valid_q;
	logic  name_valid_q;

	logic  out_free, is_end, fire_s1, in_fire;
	logic  is_dot, is_hyph, letter, legal;
	logic  total_sat, label_sat, step_fail, verdict_ok;
	logic  fail_d, prev_hyphen_d, all_letters_d;
	cnt_t  total_d, label_d;

	assign out_free = !out_valid_q || verdict.ready;
	assign is_end   = (char_s1 == CH_NUL);
	assign fire_s1  = valid_s1 && (!is_end || out_free);
	assign char_stream.ready = !valid_s1 || fire_s1;
	assign in_fire  = char_stream.valid && char_stream.ready;

	assign verdict.valid      = out_valid_q;
	assign verdict.name_valid = name_valid_q;

	always_comb begin
		is_dot    = (char_s1 == CH_DOT);
		is_hyph   = (char_s1 == CH_HYPHEN);
		letter    = is_letter(char_s1);
		legal     = letter || is_digit(char_s1) || is_hyph;
		total_sat = (total_count_q == CNT_MAX);
		label_sat = (label_count_q == CNT_MAX);

		step_fail = total_sat || (total_count_q >= max_total_q);
		total_d   = total_sat ? total_count_q : total_count_q + 8'd1;

		if (is_dot) begin
			step_fail     = step_fail || (label_count_q == '0) || prev_hyphen_q;
			label_d       = '0;
			prev_hyphen_d = 1'b0;
			all_letters_d = 1'b1;
		end else begin
			step_fail     = step_fail || ((label_count_q == '0) && is_hyph) || !legal
			                || label_sat || (label_count_q >= max_label_q);
			label_d       = label_sat ? label_count_q : label_count_q + 8'd1;
			prev_hyphen_d = is_hyph;
			all_letters_d = all_letters_q && letter;
		end
		fail_d = fail_q || step_fail;

		verdict_ok = !fail_q && (label_count_q != '0) && !prev_hyphen_q
		             && (label_count_q >= min_tld_q) && all_letters_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q   <= RST_MAX_TOTAL;
			max_label_q   <= RST_MAX_LABEL;
			min_tld_q     <= RST_MIN_TLD;
			valid_s1      <= 1'b0;
			fail_q        <= 1'b0;
			total_count_q <= '0;
			label_count_q <= '0;
			prev_hyphen_q <= 1'b0;
			all_letters_q <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_TOTAL: max_total_q <= cfg_data;
					REG_MAX_LABEL: max_label_q <= cfg_data;
					REG_MIN_TLD:   min_tld_q   <= cfg_data;
					default: ;
				endcase
			end
			if (char_stream.ready)
				valid_s1 <= char_stream.valid;
			if (fire_s1) begin
				if (is_end) begin
					fail_q        <= 1'b0;
					total_count_q <= '0;
					label_count_q <= '0;
					prev_hyphen_q <= 1'b0;
					all_letters_q <= 1'b1;
				end else begin
					fail_q        <= fail_d;
					total_count_q <= total_d;
					label_count_q <= label_d;
					prev_hyphen_q <= prev_hyphen_d;
					all_letters_q <= all_letters_d;
				end
			end
			if (fire_s1 && is_end)
				out_valid_q <= 1'b1;
			else if (verdict.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			char_s1 <= char_stream.char_in;
		if (fire_s1 && is_end)
			name_valid_q <= verdict_ok;
	end

	`DNV_ASSERT_ALWAYS(a_label_le_total, label_count_q <= total_count_q, "label count above total")
	`DNV_ASSERT_NEXT(a_end_clears, fire_s1 && is_end, out_valid_q && !fail_q && total_count_q == '0 && all_letters_q, "terminator did not clear name state")
	`DNV_ASSERT_NEXT(a_total_grows, fire_s1 && !is_end, total_count_q != '0 && total_count_q >= $past(total_count_q), "total count did not advance")
	`DNV_ASSERT_NEXT(a_fail_sticky, fire_s1 && !is_end && fail_q, fail_q, "fail flag dropped inside a name")
	`DNV_ASSERT_NEXT(a_hold_on_stall, valid_s1 && !fire_s1, valid_s1 && $stable(char_s1), "check stage lost a held item")

endmodule

// ===== dv/domain_name_validator_checker.sv =====
// ---------------------------------------------------------------------------
// Domain name validator checker
// Tracks the limit registers, predicts one verdict per terminated name from
// the accepted character items and compares each accepted verdict item.
// ---------------------------------------------------------------------------
module domain_name_validator_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  dnv_pkg::cfg_idx_t  cfg_index,
	input  dnv_pkg::cfg_data_t cfg_data,
	dnv_char_if                char_stream,
	dnv_verdict_if             verdict,
	output int                 mismatches,
	output int                 pending,
	output int                 verdicts_seen,
	output int                 valid_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import dnv_pkg::*;

	cnt_t max_total;
	cnt_t max_label;
	cnt_t min_tld;

	logic broken;
	cnt_t total_seen;
	cnt_t label_seen;
	logic after_hyphen;
	logic label_alpha;

	logic expected_verdicts[$];

	function automatic void start_name();
		broken       = 1'b0;
		total_seen   = '0;
		label_seen   = '0;
		after_hyphen = 1'b0;
		label_alpha  = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict
		char_t c;
		logic  alpha;
		logic  digit;
		logic  want;
		if (!arst_n) begin
			max_total = RST_MAX_TOTAL;
			max_label = RST_MAX_LABEL;
			min_tld   = RST_MIN_TLD;
			start_name();
			expected_verdicts.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_TOTAL: max_total = cfg_data;
					REG_MAX_LABEL: max_label = cfg_data;
					REG_MIN_TLD:   min_tld   = cfg_data;
					default: ;
				endcase
			end

			if (verdict.valid && verdict.ready) begin
				verdicts_seen++;
				if (verdict.name_valid === 1'b1)
					valid_seen++;
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					$display("%0t: name_valid expected none, actual %0b",
						$time, verdict.name_valid);
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict.name_valid !== want) begin
						mismatches++;
						$display("%0t: name_valid expected %0b, actual %0b",
							$time, want, verdict.name_valid);
					end
				end
			end

			if (char_stream.valid && char_stream.ready) begin
				c = char_stream.char_in;
				if (c == CH_NUL) begin
					expected_verdicts.push_back(!broken && label_seen != 0 && !after_hyphen
						&& label_seen >= min_tld && label_alpha);
					start_name();
				end else begin
					alpha = (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
					digit = c >= CH_DIG_0 && c <= CH_DIG_9;
					if (total_seen == CNT_MAX) begin
						broken = 1'b1;
					end else begin
						total_seen++;
						if (total_seen > max_total)
							broken = 1'b1;
					end
					if (c == CH_DOT) begin
						if (label_seen == 0 || after_hyphen)
							broken = 1'b1;
						label_seen   = '0;
						after_hyphen = 1'b0;
						label_alpha  = 1'b1;
					end else begin
						if (label_seen == 0 && c == CH_HYPHEN)
							broken = 1'b1;
						if (!(alpha || digit || c == CH_HYPHEN))
							broken = 1'b1;
						if (label_seen == CNT_MAX) begin
							broken = 1'b1;
						end else begin
							label_seen++;
							if (label_seen > max_label)
								broken = 1'b1;
						end
						after_hyphen = c == CH_HYPHEN;
						if (!alpha)
							label_alpha = 1'b0;
					end
				end
			end
		end
		pending = expected_verdicts.size();
	end

endmodule

// ===== dv/domain_name_validator_core_tb.sv =====
// ---------------------------------------------------------------------------
// Domain name validator testbench
// Streams directed and random names under several limit settings, with
// random gaps on both channels and one long verdict hold-off; the checker
// beside the block predicts and compares every verdict item.
// ---------------------------------------------------------------------------
module domain_name_validator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dnv_pkg::*;

	localparam cfg_idx_t REG_VOID    = 2'd3;
	localparam int       HOLD_CYCLES = 80;
	localparam int       PHASE_BYTES = 62;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;

	dnv_char_if    char_stream ();
	dnv_verdict_if verdict ();

	int mismatches;
	int pending;
	int verdicts_seen;
	int valid_seen;

	int    idle_pct = 12;
	bit    hold_armed = 1'b0;
	int    sent_bytes = 0;
	int    lab_lim = RST_MAX_LABEL;
	int    tld_lim = RST_MIN_TLD;
	char_t name_buf[$];

	domain_name_validator_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.char_stream (char_stream),
		.verdict     (verdict)
	);

	domain_name_validator_checker verdict_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.char_stream   (char_stream),
		.verdict       (verdict),
		.mismatches    (mismatches),
		.pending       (pending),
		.verdicts_seen (verdicts_seen),
		.valid_seen    (valid_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	function automatic bit idle_draw();
		return $urandom_range(0, 99) < idle_pct;
	endfunction

	function automatic char_t rand_letter();
		if ($urandom_range(0, 1))
			return char_t'(CH_LO_A + $urandom_range(0, 25));
		return char_t'(CH_UP_A + $urandom_range(0, 25));
	endfunction

	function automatic char_t rand_alnum();
		if ($urandom_range(0, 2) == 0)
			return char_t'(CH_DIG_0 + $urandom_range(0, 9));
		return rand_letter();
	endfunction

	// mostly well-formed names sized around the current limits, some damaged
	function automatic void build_name();
		int mode;
		int labels;
		int len;
		int cap;
		int tld_cap;
		int pos;
		name_buf.delete();
		mode = $urandom_range(0, 99);
		if (mode < 4)
			return;
		cap     = (lab_lim + 1 < 10) ? lab_lim + 1 : 10;
		tld_cap = (tld_lim + 2 < 10) ? tld_lim + 2 : 10;
		if (cap < 1)
			cap = 1;
		labels = $urandom_range(1, 4);
		for (int k = 0; k < labels; k++) begin
			len = (k == labels - 1) ? $urandom_range(1, tld_cap) : $urandom_range(1, cap);
			for (int j = 0; j < len; j++) begin
				if (k == labels - 1)
					name_buf.push_back(($urandom_range(0, 9) == 0) ? rand_alnum() : rand_letter());
				else if (j == 0 || j == len - 1 || $urandom_range(0, 9) < 8)
					name_buf.push_back(rand_alnum());
				else
					name_buf.push_back(CH_HYPHEN);
			end
			if (k < labels - 1)
				name_buf.push_back(CH_DOT);
		end
		if (mode >= 72) begin
			pos = $urandom_range(0, name_buf.size());
			case ($urandom_range(0, 5))
				0: name_buf.insert(pos, char_t'($urandom_range(1, 255)));
				1: name_buf.push_front(CH_HYPHEN);
				2: name_buf.insert(pos, CH_HYPHEN);
				3: name_buf.insert(pos, CH_DOT);
				4: name_buf.push_back(CH_DOT);
				default: name_buf.push_back(CH_HYPHEN);
			endcase
		end
	endfunction

	task automatic send_char(input char_t c);
		bit taken;
		while (idle_draw()) begin
			char_stream.valid <= 1'b0;
			@(posedge clk);
		end
		char_stream.valid   <= 1'b1;
		char_stream.char_in <= c;
		do begin
			@(negedge clk);
			taken = char_stream.ready;
			@(posedge clk);
		end while (!taken);
		sent_bytes++;
	endtask

	task automatic send_name();
		foreach (name_buf[i])
			send_char(name_buf[i]);
		send_char(CH_NUL);
	endtask

	task automatic send_text(input string s);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++)
			name_buf.push_back(char_t'(s[i]));
		send_name();
	endtask

	task automatic drain();
		char_stream.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic program_limits(input int t, input int l, input int d);
		lab_lim   = l;
		tld_lim   = d;
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_TOTAL;
		cfg_data  <= cfg_data_t'(t);
		@(posedge clk);
		cfg_index <= REG_MAX_LABEL;
		cfg_data  <= cfg_data_t'(l);
		@(posedge clk);
		cfg_index <= REG_MIN_TLD;
		cfg_data  <= cfg_data_t'(d);
		@(posedge clk);
		cfg_index <= REG_VOID;
		cfg_data  <= cfg_data_t'($urandom_range(0, 255));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : verdict_sink
		int hold_left;
		hold_left = 0;
		verdict.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				verdict.ready <= 1'b0;
			end else if (hold_armed) begin
				hold_armed = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				verdict.ready <= 1'b0;
			end else begin
				verdict.ready <= !idle_draw();
			end
		end
	end

	initial begin : stimulus
		int phase_start;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_MAX_TOTAL;
		cfg_data            <= '0;
		char_stream.valid   <= 1'b0;
		char_stream.char_in <= CH_NUL;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("");
		send_text("x-9.Zz");
		send_text(".ab");
		send_text("a..bc");
		send_text("ab.");
		send_text("-q.bc");

		for (int p = 0; p < 8; p++) begin
			drain();
			case (p)
				0: program_limits(255, 255, 1);
				1: program_limits(1, 1, 1);
				2: program_limits(0, 63, 0);
				3: program_limits(253, 0, 255);
				5: program_limits(RST_MAX_TOTAL, RST_MAX_LABEL, RST_MIN_TLD);
				default: program_limits($urandom_range(4, 40), $urandom_range(1, 12),
					$urandom_range(1, 5));
			endcase
			idle_pct = (p == 5) ? 0 : 12;
			if (p == 4)
				hold_armed = 1'b1;
			if (p == 0) begin
				name_buf.delete();
				repeat (258) name_buf.push_back(rand_letter());
				send_name();
			end
			phase_start = sent_bytes;
			while (sent_bytes - phase_start < PHASE_BYTES) begin
				build_name();
				send_name();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Summary: %0d bytes sent, %0d verdicts checked, %0d of them valid.",
			sent_bytes, verdicts_seen, valid_seen);
		$display("Covered default, extreme, zero and random limits, a 258-byte name, %0s",
			"and a long verdict hold-off.");
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
